// File: rtl/swg_pkg.sv
`default_nettype none
package swg_pkg;

  localparam int DATA_WIDTH   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 33;
  localparam int MAC_W     = 66;
  localparam int ROT_W     = 34;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd6;

  localparam logic MODE_INTERNAL = 1'b0;
  localparam logic MODE_EXTERNAL = 1'b1;

  // multiply-accumulate operations
  localparam logic [2:0] MAC_ANG = 3'd0;
  localparam logic [2:0] MAC_P0  = 3'd1;
  localparam logic [2:0] MAC_P1  = 3'd2;
  localparam logic [2:0] MAC_P2  = 3'd3;
  localparam logic [2:0] MAC_P3  = 3'd4;
  localparam logic [2:0] MAC_AMP = 3'd5;

  // 1/(2*pi) in Q0.64, split in halves
  localparam logic [WORD_W-1:0] INV2PI_HI = 32'h28BE60DB;
  localparam logic [WORD_W-1:0] INV2PI_LO = 32'h9391054A;

  localparam logic signed [ROT_W-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [ROT_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ROT_W-1:0] NEG_QUARTER  = -34'sd1073741824;
  localparam logic signed [ROT_W-1:0] HALF_TURN    = 34'sd2147483648;

  localparam logic signed [MAC_W-1:0] MAC_ROUND = 66'sd536870912;
  localparam logic signed [MAC_W-1:0] SAT_MAX   = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
  localparam logic signed [MAC_W-1:0] SAT_MIN   = -(66'sd1 <<< (DATA_WIDTH - 1));

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] amplitude;
    logic [WORD_W-1:0] frequency;
    logic [WORD_W-1:0] phase;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] accumulator;
  } cfg_t;

  typedef struct packed {
    logic              load_x;
    logic              mac_en;
    logic [2:0]        mac_op;
    logic              fold;
    logic              rot;
    logic [ITER_W-1:0] iter;
    logic              sine;
    logic              y_load;
  } cmd_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [WORD_W-1:0] atan_turn(input logic [4:0] i);
    logic [WORD_W-1:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: rtl/swg_if.sv
`default_nettype none
interface swg_x_if;
  logic                      valid;
  logic                      ready;
  logic [swg_pkg::WORD_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface swg_y_if;
  logic                      valid;
  logic                      ready;
  logic [swg_pkg::WORD_W-1:0] y_value;

  modport source (output valid, output y_value, input ready);
  modport sink   (input valid, input y_value, output ready);
endinterface
`default_nettype wire

// File: rtl/swg_cfg.sv
`default_nettype none
module swg_cfg
  import swg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 acc_step,
  output cfg_t                 cfg
);

  logic              mode_r;
  logic [WORD_W-1:0] amplitude_r;
  logic [WORD_W-1:0] frequency_r;
  logic [WORD_W-1:0] phase_r;
  logic [WORD_W-1:0] offset_r;
  logic [WORD_W-1:0] step_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (cfg_we && cfg_idx == REG_INIT) begin
      acc_nxt = cfg_wdata;
    end else if (acc_step && mode_r == MODE_INTERNAL) begin
      acc_nxt = acc_r + step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_INTERNAL;
      amplitude_r <= 32'd65536;
      frequency_r <= 32'd65536;
      phase_r     <= '0;
      offset_r    <= '0;
      step_r      <= 32'd196608;
      acc_r       <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_MODE:      mode_r      <= cfg_wdata[0];
          REG_AMPLITUDE: amplitude_r <= cfg_wdata;
          REG_FREQUENCY: frequency_r <= cfg_wdata;
          REG_PHASE:     phase_r     <= cfg_wdata;
          REG_OFFSET:    offset_r    <= cfg_wdata;
          REG_STEP:      step_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign cfg.mode        = mode_r;
  assign cfg.amplitude   = amplitude_r;
  assign cfg.frequency   = frequency_r;
  assign cfg.phase       = phase_r;
  assign cfg.offset      = offset_r;
  assign cfg.accumulator = acc_r;

endmodule
`default_nettype wire

// File: rtl/swg_ctrl.sv
`default_nettype none
module swg_ctrl
  import swg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ANG  = 4'd1;
  localparam logic [3:0] ST_P0   = 4'd2;
  localparam logic [3:0] ST_P1   = 4'd3;
  localparam logic [3:0] ST_P2   = 4'd4;
  localparam logic [3:0] ST_P3   = 4'd5;
  localparam logic [3:0] ST_FOLD = 4'd6;
  localparam logic [3:0] ST_ROT  = 4'd7;
  localparam logic [3:0] ST_SINE = 4'd8;
  localparam logic [3:0] ST_AMP  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0]        state_r;
  logic [3:0]        state_nxt;
  logic [ITER_W-1:0] iter_r;
  logic [ITER_W-1:0] iter_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.iter  = iter_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_nxt  = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd.mac_en = 1'b1;
        cmd.mac_op = MAC_ANG;
        state_nxt  = ST_P0;
      end
      ST_P0: begin
        cmd.mac_en = 1'b1;
        cmd.mac_op = MAC_P0;
        state_nxt  = ST_P1;
      end
      ST_P1: begin
        cmd.mac_en = 1'b1;
        cmd.mac_op = MAC_P1;
        state_nxt  = ST_P2;
      end
      ST_P2: begin
        cmd.mac_en = 1'b1;
        cmd.mac_op = MAC_P2;
        state_nxt  = ST_P3;
      end
      ST_P3: begin
        cmd.mac_en = 1'b1;
        cmd.mac_op = MAC_P3;
        state_nxt  = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        iter_nxt  = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot  = 1'b1;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_LAST) begin
          state_nxt = ST_SINE;
        end
      end
      ST_SINE: begin
        cmd.sine  = 1'b1;
        state_nxt = ST_AMP;
      end
      ST_AMP: begin
        cmd.mac_en = 1'b1;
        cmd.mac_op = MAC_AMP;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.y_load = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.y_load | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/swg_dp.sv
`default_nettype none
module swg_dp
  import swg_pkg::*;
(
  input  logic              clk,
  input  cmd_t              cmd,
  input  cfg_t              cfg,
  input  logic [WORD_W-1:0] in_x,
  output logic [WORD_W-1:0] y_value
);

  logic [WORD_W-1:0]       x_r;
  logic [2*WORD_W-1:0]     a_r;
  logic signed [MAC_W-1:0] acc_r;
  logic signed [ROT_W-1:0] z_r;
  logic signed [ROT_W-1:0] cx_r;
  logic signed [ROT_W-1:0] cy_r;
  logic                    neg_r;
  logic signed [WORD_W-1:0] s_r;
  logic [WORD_W-1:0]       y_r;

  logic signed [OP_W-1:0]  opa;
  logic signed [OP_W-1:0]  opb;
  logic signed [MAC_W-1:0] addend;
  logic signed [MAC_W-1:0] prod;
  logic signed [MAC_W-1:0] mac_sum;

  logic signed [ROT_W-1:0] z0;
  logic signed [ROT_W-1:0] z_fold;
  logic                    neg_fold;
  logic signed [ROT_W-1:0] dx;
  logic signed [ROT_W-1:0] dy;
  logic signed [ROT_W-1:0] atn;
  logic signed [ROT_W-1:0] clamp;
  logic signed [ROT_W-1:0] s_nxt;
  logic signed [MAC_W-1:0] y_wide;
  logic signed [MAC_W-1:0] y_sat;

  // shared multiplier: angle, four partial products of the turn word, gain
  always_comb begin
    opa    = '0;
    opb    = '0;
    addend = '0;
    case (cmd.mac_op)
      MAC_ANG: begin
        opa    = {cfg.frequency[WORD_W-1], cfg.frequency};
        opb    = {x_r[WORD_W-1], x_r};
        addend = {{18{cfg.phase[WORD_W-1]}}, cfg.phase, 16'd0};
      end
      MAC_P0: begin
        opa = {1'b0, a_r[WORD_W-1:0]};
        opb = {1'b0, INV2PI_LO};
      end
      MAC_P1: begin
        opa    = {a_r[2*WORD_W-1], a_r[2*WORD_W-1:WORD_W]};
        opb    = {1'b0, INV2PI_LO};
        addend = acc_r >>> WORD_W;
      end
      MAC_P2: begin
        opa    = {1'b0, a_r[WORD_W-1:0]};
        opb    = {1'b0, INV2PI_HI};
        addend = acc_r;
      end
      MAC_P3: begin
        opa    = {a_r[2*WORD_W-1], a_r[2*WORD_W-1:WORD_W]};
        opb    = {1'b0, INV2PI_HI};
        addend = acc_r >>> WORD_W;
      end
      MAC_AMP: begin
        opa    = {cfg.amplitude[WORD_W-1], cfg.amplitude};
        opb    = {s_r[WORD_W-1], s_r};
        addend = MAC_ROUND;
      end
      default: ;
    endcase
  end

  assign prod    = opa * opb;
  assign mac_sum = prod + addend;

  // fold to the half turn around zero
  always_comb begin
    z0       = {{2{acc_r[WORD_W-1]}}, acc_r[WORD_W-1:0]};
    z_fold   = z0;
    neg_fold = 1'b0;
    if (z0 >= QUARTER_TURN) begin
      z_fold   = z0 - HALF_TURN;
      neg_fold = 1'b1;
    end else if (z0 < NEG_QUARTER) begin
      z_fold   = z0 + HALF_TURN;
      neg_fold = 1'b1;
    end
  end

  assign dx  = cy_r >>> cmd.iter;
  assign dy  = cx_r >>> cmd.iter;
  assign atn = {2'b00, atan_turn(5'(cmd.iter))};

  always_comb begin
    if (cy_r > QUARTER_TURN) begin
      clamp = QUARTER_TURN;
    end else if (cy_r < NEG_QUARTER) begin
      clamp = NEG_QUARTER;
    end else begin
      clamp = cy_r;
    end
    s_nxt = neg_r ? -clamp : clamp;
  end

  always_comb begin
    y_wide = (acc_r >>> 30)
           + $signed({{(MAC_W-WORD_W){cfg.offset[WORD_W-1]}}, cfg.offset});
    if (y_wide > SAT_MAX) begin
      y_sat = SAT_MAX;
    end else if (y_wide < SAT_MIN) begin
      y_sat = SAT_MIN;
    end else begin
      y_sat = y_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_r <= (cfg.mode == MODE_EXTERNAL) ? in_x : cfg.accumulator;
    end
    if (cmd.mac_en) begin
      acc_r <= mac_sum;
      if (cmd.mac_op == MAC_ANG) begin
        a_r <= mac_sum[2*WORD_W-1:0];
      end
    end
    if (cmd.fold) begin
      z_r   <= z_fold;
      neg_r <= neg_fold;
      cx_r  <= CORDIC_GAIN;
      cy_r  <= '0;
    end else if (cmd.rot) begin
      if (!z_r[ROT_W-1]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - atn;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + atn;
      end
    end
    if (cmd.sine) begin
      s_r <= s_nxt[WORD_W-1:0];
    end
    if (cmd.y_load) begin
      y_r <= y_sat[WORD_W-1:0];
    end
  end

  assign y_value = y_r;

endmodule
`default_nettype wire

// File: rtl/sine_wave_generator.sv
// Sine wave generator: y = amplitude * sin(frequency * x + phase) + offset,
// all words signed Q16.16.
// in_if carries x_value; in internal mode the word is only a tick and x is
// the phase accumulator, which advances by step on every accepted word.
// out_if returns one y_value word per input word, saturated.
// cfg_we/cfg_idx/cfg_wdata write the registers (mode, amplitude, frequency,
// phase, offset, init_value, step); writing init_value reloads the
// accumulator. Write only while the block is idle.
// One word is processed at a time: in_if.ready is high only when idle.
// The result is registered after the angle pass, four turn-word passes,
// fold, CORDIC steps, sine and gain pass, and the block is idle again as
// it is loaded. The word rate is set by the single shared 33x33 multiplier
// (six passes) and the iterative CORDIC rotator (one step per cycle).
// The output register holds its word while out_if.ready is low; a finished
// word waits in the datapath and the block stays busy until it can be loaded.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// accumulator and empties the output.
`default_nettype none
module sine_wave_generator
  import swg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  swg_x_if.sink                in_if,
  swg_y_if.source              out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  cfg_t cfg;
  cmd_t cmd;
  logic in_fire;

  assign in_fire = in_if.valid & in_if.ready;

  swg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .acc_step  (in_fire),
    .cfg       (cfg)
  );

  swg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .out_ready (out_if.ready),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .cmd       (cmd)
  );

  swg_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .cfg     (cfg),
    .in_x    (in_if.x_value),
    .y_value (out_if.y_value)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("input accepted twice in a row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_load |-> (!out_if.valid || out_if.ready))
    else $error("result word overwritten before being taken");

  a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mac_en || cmd.rot) |-> !in_if.ready)
    else $error("ready raised while datapath busy");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.y_load))
    else $error("result valid without a load");
`endif

endmodule
`default_nettype wire
